>>> sv/cnqe_pkg.sv
// Package for the cube net quad expander: codes, payload structs, net and corner tables.
`default_nettype none

package cnqe_pkg;

   // Fixed point and word ranges
   localparam int CNQE_FRAC_BITS = 16;
   localparam logic signed [31:0] W32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] W32_MIN = 32'sh8000_0000;

   // Operation codes
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_CUBE = 1'b1;

   // Row code that a load ignores
   localparam logic [1:0] ROW_NONE = 2'd3;

   // Face codes
   localparam logic [2:0] FACE_RIGHT  = 3'd0;
   localparam logic [2:0] FACE_FRONT  = 3'd1;
   localparam logic [2:0] FACE_LEFT   = 3'd2;
   localparam logic [2:0] FACE_BACK   = 3'd3;
   localparam logic [2:0] FACE_TOP    = 3'd4;
   localparam logic [2:0] FACE_BOTTOM = 3'd5;

   // Index of the final vertex of a cube
   localparam logic [4:0] LAST_VERTEX = 5'd23;

   // Net term multipliers, packed {w, h, d}, two bits each
   localparam logic [5:0] C_0   = 6'b00_00_00;
   localparam logic [5:0] C_W   = 6'b01_00_00;
   localparam logic [5:0] C_H   = 6'b00_01_00;
   localparam logic [5:0] C_D   = 6'b00_00_01;
   localparam logic [5:0] C_WD  = 6'b01_00_01;
   localparam logic [5:0] C_W2D = 6'b01_00_10;

   // One vertex leaving the sequencer
   typedef struct packed {
      logic              valid;
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [31:0] texel_u;
      logic signed [31:0] texel_v;
      logic [2:0]        face;
      logic              last;
   } vertex_type;

   // Transform row write
   typedef struct packed {
      logic              en;
      logic [1:0]        row;
      logic signed [31:0] c0;
      logic signed [31:0] c1;
      logic signed [31:0] c2;
      logic signed [31:0] t;
   } xform_wr_type;

   // Saturate a 36-bit sum to 32 bits
   function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
      logic in_range;
      in_range = (&x[35:31]) || !(|x[35:31]);
      if (in_range) begin
         return x[31:0];
      end else if (x[35]) begin
         return W32_MIN;
      end else begin
         return W32_MAX;
      end
   endfunction

   // Net terms of a face: {v size, u size, v offset, u offset}
   function automatic logic [23:0] net_coef(input logic [2:0] face);
      logic [23:0] res;
      unique case (face)
         FACE_RIGHT:  res = {C_H, C_D, C_D, C_0};
         FACE_FRONT:  res = {C_H, C_W, C_D, C_D};
         FACE_LEFT:   res = {C_H, C_D, C_D, C_WD};
         FACE_BACK:   res = {C_H, C_W, C_D, C_W2D};
         FACE_TOP:    res = {C_D, C_W, C_0, C_D};
         FACE_BOTTOM: res = {C_D, C_W, C_0, C_WD};
         default:     res = '0;
      endcase
      return res;
   endfunction

   // Small multiplier 0, 1 or 2 times a word
   function automatic logic signed [35:0] net_scale(input logic [1:0] c,
                                                   input logic signed [31:0] x);
      logic signed [35:0] res;
      unique case (c)
         2'd1:    res = 36'(x);
         2'd2:    res = 36'(x) <<< 1;
         default: res = '0;
      endcase
      return res;
   endfunction

   // Corner selects {x hi, y hi, z hi, u size, v size}
   function automatic logic [4:0] corner_sel(input logic [2:0] face,
                                            input logic [1:0] corner);
      logic [19:0] row;
      // packed corner 3 down to corner 0
      unique case (face)
         FACE_RIGHT:  row = 20'b01010_01100_00101_00011;
         FACE_FRONT:  row = 20'b00001_10011_11010_01000;
         FACE_LEFT:   row = 20'b11110_11000_10001_10111;
         FACE_BACK:   row = 20'b10101_00111_01110_11100;
         FACE_TOP:    row = 20'b01001_11011_11110_01100;
         FACE_BOTTOM: row = 20'b00101_10111_10010_00000;
         default:     row = '0;
      endcase
      return row[corner*5 +: 5];
   endfunction

endpackage

`default_nettype wire

>>> sv/cnqe_if.sv
// Request and response channel interfaces of the cube net quad expander.
`default_nettype none

interface cnqe_req_if;
   logic              valid;
   logic              ready;
   logic              op;
   logic [1:0]        row;
   logic signed [31:0] origin_x;
   logic signed [31:0] origin_y;
   logic signed [31:0] origin_z;
   logic signed [31:0] size_w;
   logic signed [31:0] size_h;
   logic signed [31:0] size_d;
   logic signed [31:0] inflate;
   logic signed [31:0] net_u;
   logic signed [31:0] net_v;
   logic              mirror;

   modport source (
      output valid, op, row, origin_x, origin_y, origin_z, size_w, size_h, size_d,
             inflate, net_u, net_v, mirror,
      input  ready
   );
   modport sink (
      input  valid, op, row, origin_x, origin_y, origin_z, size_w, size_h, size_d,
             inflate, net_u, net_v, mirror,
      output ready
   );
endinterface

interface cnqe_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [31:0] world_x;
   logic signed [31:0] world_y;
   logic signed [31:0] world_z;
   logic signed [31:0] texel_u;
   logic signed [31:0] texel_v;
   logic [2:0]        face;
   logic              last;

   modport source (
      output valid, world_x, world_y, world_z, texel_u, texel_v, face, last,
      input  ready
   );
   modport sink (
      input  valid, world_x, world_y, world_z, texel_u, texel_v, face, last,
      output ready
   );
endinterface

`default_nettype wire

>>> sv/cube_net_quad_expand_core.sv
// Cube net quad expander top level: vertex sequencer feeding the transform pipeline.
// Vertices pass the vertex register, product stage and response register in that order.
// One vertex per cycle while the response register is free; the vertex counter sets it.
// Load transactions wait until idle and no vertex waits ahead of the multipliers.
// Reset (synchronous, active high) restores the identity transform and empties the pipe.
`default_nettype none

module cube_net_quad_expand_core
   import cnqe_pkg::*;
#(
   parameter int FRAC_BITS = CNQE_FRAC_BITS
)
(
   input  logic       clock,
   input  logic       reset,
   cnqe_req_if.sink   req_ch,
   cnqe_rsp_if.source rsp_ch
);

   vertex_type   vtx;
   xform_wr_type wr;
   logic         adv;

   // Whole pipeline moves when the response register is free
   assign adv = !rsp_ch.valid || rsp_ch.ready;

   cnqe_vertex_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .adv    (adv),
      .vtx    (vtx),
      .wr     (wr)
   );

   cnqe_xform #(
      .FRAC_BITS (FRAC_BITS)
   ) u_xform (
      .clock  (clock),
      .reset  (reset),
      .vtx    (vtx),
      .wr     (wr),
      .adv    (adv),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

>>> sv/cnqe_vertex_seq.sv
// Cube capture and vertex sequencer: box extents, texel net and corner selection.
`default_nettype none

module cnqe_vertex_seq
   import cnqe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   cnqe_req_if.sink      req_ch,
   input  logic          adv,
   output vertex_type    vtx,
   output xform_wr_type  wr
);

   logic               busy_ff, busy_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic signed [31:0] lo_ff [3];
   logic signed [31:0] hi_ff [3];
   logic signed [31:0] wd_ff, ht_ff, dp_ff, nu_ff, nv_ff;
   logic               mirror_ff;
   vertex_type         vtx_ff, vtx_in;

   logic accept, cube_acc, load_acc, at_end;

   // Request handshake: loads wait until the sequencer is idle and no vertex sits ahead of the multipliers
   assign at_end = (cnt_ff == LAST_VERTEX);
   always_comb begin
      if (req_ch.op == OP_LOAD) begin
         req_ch.ready = !busy_ff && !vtx_ff.valid;
      end else begin
         req_ch.ready = !busy_ff || (at_end && adv);
      end
   end
   assign accept   = req_ch.valid && req_ch.ready;
   assign cube_acc = accept && (req_ch.op == OP_CUBE);
   assign load_acc = accept && (req_ch.op == OP_LOAD);

   // Transform row write
   always_comb begin
      wr.en  = load_acc && (req_ch.row != ROW_NONE);
      wr.row = req_ch.row;
      wr.c0  = req_ch.origin_x;
      wr.c1  = req_ch.origin_y;
      wr.c2  = req_ch.origin_z;
      wr.t   = req_ch.size_w;
   end

   // Vertex counter
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (busy_ff && adv) begin
         if (at_end) begin
            busy_in = 1'b0;
            cnt_in  = '0;
         end else begin
            cnt_in = cnt_ff + 5'd1;
         end
      end
      if (cube_acc) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Held cube: saturated low and high extents
   always_ff @(posedge clock) begin
      if (cube_acc) begin
         lo_ff[0]  <= sat32(36'(req_ch.origin_x) - 36'(req_ch.inflate));
         lo_ff[1]  <= sat32(36'(req_ch.origin_y) - 36'(req_ch.inflate));
         lo_ff[2]  <= sat32(36'(req_ch.origin_z) - 36'(req_ch.inflate));
         hi_ff[0]  <= sat32(36'(req_ch.origin_x) + 36'(req_ch.size_w)
                            + 36'(req_ch.inflate));
         hi_ff[1]  <= sat32(36'(req_ch.origin_y) + 36'(req_ch.size_h)
                            + 36'(req_ch.inflate));
         hi_ff[2]  <= sat32(36'(req_ch.origin_z) + 36'(req_ch.size_d)
                            + 36'(req_ch.inflate));
         wd_ff     <= req_ch.size_w;
         ht_ff     <= req_ch.size_h;
         dp_ff     <= req_ch.size_d;
         nu_ff     <= req_ch.net_u;
         nv_ff     <= req_ch.net_v;
         mirror_ff <= req_ch.mirror;
      end
   end

   // Vertex of the current count: corner position and texel
   always_comb begin
      logic [2:0]         face;
      logic [1:0]         corner;
      logic [4:0]         sel;
      logic [23:0]        coef;
      logic signed [35:0] term [4];
      logic signed [35:0] u_raw, v_raw, u_fin;

      face   = cnt_ff[4:2];
      corner = ~cnt_ff[1:0];
      sel    = corner_sel(face, corner);
      coef   = net_coef(face);
      for (int i = 0; i < 4; i++) begin
         term[i] = net_scale(coef[i*6+4 +: 2], wd_ff) + net_scale(coef[i*6+2 +: 2], ht_ff)
                   + net_scale(coef[i*6 +: 2], dp_ff);
      end
      u_raw = 36'(nu_ff) + term[0] + (sel[1] ? term[2] : 36'sd0);
      v_raw = 36'(nv_ff) + term[1] + (sel[0] ? term[3] : 36'sd0);
      // mirror reflects u about the middle of the net
      if (mirror_ff) begin
         u_fin = (36'(nu_ff) <<< 1) + ((36'(wd_ff) + 36'(dp_ff)) <<< 1) - u_raw;
      end else begin
         u_fin = u_raw;
      end

      vtx_in.valid   = busy_ff;
      vtx_in.px      = sel[4] ? hi_ff[0] : lo_ff[0];
      vtx_in.py      = sel[3] ? hi_ff[1] : lo_ff[1];
      vtx_in.pz      = sel[2] ? hi_ff[2] : lo_ff[2];
      vtx_in.texel_u = sat32(u_fin);
      vtx_in.texel_v = sat32(v_raw);
      vtx_in.face    = face;
      vtx_in.last    = at_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vtx_ff.valid <= 1'b0;
      end else if (adv) begin
         vtx_ff <= vtx_in;
      end
   end

   assign vtx = vtx_ff;

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LAST_VERTEX)
      else $error("vertex counter beyond last vertex");
   a_idle_cnt_zero: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (cnt_ff == 5'd0))
      else $error("idle sequencer with nonzero count");
   a_last_bottom: assert property (@(posedge clock) disable iff (reset)
      (vtx_ff.valid && vtx_ff.last) |-> (vtx_ff.face == FACE_BOTTOM))
      else $error("last vertex not on bottom face");
`endif

endmodule

`default_nettype wire

>>> sv/cnqe_xform.sv
// Affine transform store, product stage and saturating sum into the response register.
`default_nettype none

module cnqe_xform
   import cnqe_pkg::*;
#(
   parameter int FRAC_BITS = CNQE_FRAC_BITS
)
(
   input  logic          clock,
   input  logic          reset,
   input  vertex_type    vtx,
   input  xform_wr_type  wr,
   input  logic          adv,
   cnqe_rsp_if.source    rsp_ch
);

   localparam int PW = 64 - FRAC_BITS;
   localparam int SW = PW + 2;
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   logic signed [31:0]   mat_ff [12];
   logic signed [PW-1:0] prod_ff [3][3];
   logic signed [PW-1:0] prod_in [3][3];
   logic signed [31:0]   trans_ff [3];
   logic                 s2_valid_ff;
   logic signed [31:0]   s2_u_ff, s2_v_ff;
   logic [2:0]           s2_face_ff;
   logic                 s2_last_ff;

   logic                 out_valid_ff;
   logic signed [31:0]   world_ff [3];
   logic signed [31:0]   out_u_ff, out_v_ff;
   logic [2:0]           out_face_ff;
   logic                 out_last_ff;

   function automatic logic signed [31:0] sat_sum(input logic signed [SW-1:0] x);
      logic in_range;
      in_range = (&x[SW-1:31]) || !(|x[SW-1:31]);
      if (in_range) begin
         return x[31:0];
      end else if (x[SW-1]) begin
         return W32_MIN;
      end else begin
         return W32_MAX;
      end
   endfunction

   // Transform rows, identity after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 12; i++) begin
            mat_ff[i] <= (i == 0 || i == 5 || i == 10) ? ONE : 32'sd0;
         end
      end else if (wr.en) begin
         mat_ff[{wr.row, 2'd0}] <= wr.c0;
         mat_ff[{wr.row, 2'd1}] <= wr.c1;
         mat_ff[{wr.row, 2'd2}] <= wr.c2;
         mat_ff[{wr.row, 2'd3}] <= wr.t;
      end
   end

   // Products, floored by the fraction shift
   always_comb begin
      logic signed [31:0] pv [3];
      logic signed [63:0] full;
      logic signed [63:0] shifted;
      pv[0] = vtx.px;
      pv[1] = vtx.py;
      pv[2] = vtx.pz;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            full          = mat_ff[4'(r*4+c)] * pv[c];
            shifted       = full >>> FRAC_BITS;
            prod_in[r][c] = shifted[PW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= vtx.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff    <= prod_in;
         for (int r = 0; r < 3; r++) begin
            trans_ff[r] <= mat_ff[4'(r*4+3)];
         end
         s2_u_ff    <= vtx.texel_u;
         s2_v_ff    <= vtx.texel_v;
         s2_face_ff <= vtx.face;
         s2_last_ff <= vtx.last;
      end
   end

   // Sum of products and translation, saturated, into the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int r = 0; r < 3; r++) begin
            world_ff[r] <= sat_sum(SW'(prod_ff[r][0]) + SW'(prod_ff[r][1])
                                   + SW'(prod_ff[r][2]) + SW'(trans_ff[r]));
         end
         out_u_ff    <= s2_u_ff;
         out_v_ff    <= s2_v_ff;
         out_face_ff <= s2_face_ff;
         out_last_ff <= s2_last_ff;
      end
   end

   assign rsp_ch.valid   = out_valid_ff;
   assign rsp_ch.world_x = world_ff[0];
   assign rsp_ch.world_y = world_ff[1];
   assign rsp_ch.world_z = world_ff[2];
   assign rsp_ch.texel_u = out_u_ff;
   assign rsp_ch.texel_v = out_v_ff;
   assign rsp_ch.face    = out_face_ff;
   assign rsp_ch.last    = out_last_ff;

`ifndef SYNTHESIS
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !adv) |=> s2_valid_ff)
      else $error("product stage lost a vertex under stall");
   a_out_last_bottom: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_face_ff == FACE_BOTTOM))
      else $error("last response not on bottom face");
`endif

endmodule

`default_nettype wire
